FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and codes for the LRU buffer cache tag controller.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int OP_W   = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 8;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ACQUIRE   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE   = 2'd2;
    localparam logic [OP_W-1:0] OP_DISK_DONE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_HELD   = 2'd2;
    localparam logic [ST_W-1:0] ST_COUNT_FULL = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
    localparam logic [CNT_W-1:0] CNT_ONE = 8'h01;

    localparam logic [1:0] SCAN_HIT  = 2'd0;
    localparam logic [1:0] SCAN_FREE = 2'd1;
    localparam logic [1:0] SCAN_FIND = 2'd2;

    localparam logic [2:0] UPD_HIT   = 3'd0;
    localparam logic [2:0] UPD_ALLOC = 3'd1;
    localparam logic [2:0] UPD_DIRTY = 3'd2;
    localparam logic [2:0] UPD_REL   = 3'd3;
    localparam logic [2:0] UPD_DONE  = 3'd4;

    localparam logic [2:0] RES_HIT      = 3'd0;
    localparam logic [2:0] RES_FULL     = 3'd1;
    localparam logic [2:0] RES_ALLOC    = 3'd2;
    localparam logic [2:0] RES_NO_FREE  = 3'd3;
    localparam logic [2:0] RES_NOT_HELD = 3'd4;
    localparam logic [2:0] RES_WRITE    = 3'd5;
    localparam logic [2:0] RES_OK       = 3'd6;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] cnt;
        logic             valid;
        logic             dirty;
    } t_rec;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic [1:0] scan_kind;
        logic       rd_slot;
        logic       cap_slot;
        logic       rec_upd;
        logic [2:0] upd_kind;
        logic       res_set;
        logic [2:0] res_kind;
        logic       shift_start;
        logic       front;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic            scan_match;
        logic            scan_end;
        logic            cnt_full;
        logic            cnt_one;
        logic            not_held;
        logic            shift_busy;
        logic            out_free;
        logic [OP_W-1:0] op;
    } t_sts;

endpackage

FILE: rtl/block_buffer_cache_lru_top.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top
// Tag manager of a disk buffer cache with least-recently-used recycling.
// ----------------------------------------------------------------------------
// The request channel (i_valid, o_stall) carries one beat per operation:
// acquire, write, release or disk done. The response channel (o_valid,
// i_stall) returns exactly one beat per request, in request order.
// A request is taken only while the controller is idle. Acquire scans the
// recency order front to back at one entry per cycle; on a miss, the victim
// search walks the order again from the back. A release that frees an entry
// walks the order to find it and shifts the entries in front of it down.
// A finished response sits in the output register; while the receiver
// stalls, the next request is still taken and worked on, and its response
// waits in the controller until the output register drains.
// Reset empties the pipeline and marks every entry as untouched, so all
// entries read back with zero tags and counts and the default order.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_top #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [bbc_pkg::OP_W-1:0]   i_op,
    input  logic [bbc_pkg::DEV_W-1:0]  i_device,
    input  logic [bbc_pkg::BLK_W-1:0]  i_block_number,
    input  logic [bbc_pkg::SLOT_W-1:0] i_slot,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bbc_pkg::SLOT_W-1:0] o_slot_out,
    output logic                       o_hit,
    output logic                       o_needs_read,
    output logic                       o_needs_write,
    output logic [bbc_pkg::ST_W-1:0]   o_status
);
    import bbc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bbc_dp #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_op),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_slot_out     (o_slot_out),
        .o_hit          (o_hit),
        .o_needs_read   (o_needs_read),
        .o_needs_write  (o_needs_write),
        .o_status       (o_status)
    );

endmodule

FILE: rtl/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer that steps the datapath through lookup, allocation and update.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bbc_pkg::t_sts i_sts,
    output bbc_pkg::t_cmd o_cmd
);
    import bbc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HSTART  = 4'd1;
    localparam logic [3:0] S_HSCAN   = 4'd2;
    localparam logic [3:0] S_HEVAL   = 4'd3;
    localparam logic [3:0] S_FSTART  = 4'd4;
    localparam logic [3:0] S_FSCAN   = 4'd5;
    localparam logic [3:0] S_ALLOC   = 4'd6;
    localparam logic [3:0] S_SREAD   = 4'd7;
    localparam logic [3:0] S_SCHECK  = 4'd8;
    localparam logic [3:0] S_UPD     = 4'd9;
    localparam logic [3:0] S_MSTART  = 4'd10;
    localparam logic [3:0] S_MSCAN   = 4'd11;
    localparam logic [3:0] S_SHSTART = 4'd12;
    localparam logic [3:0] S_SHIFT   = 4'd13;
    localparam logic [3:0] S_FRONT   = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SREAD;
                    if (i_sts.op == OP_ACQUIRE) begin
                        n_state = S_HSTART;
                    end
                end
            end
            S_HSTART: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind  = SCAN_HIT;
                n_state          = S_HSCAN;
            end
            S_HSCAN: begin
                if (i_sts.scan_match) begin
                    n_state = S_HEVAL;
                end else if (i_sts.scan_end) begin
                    n_state = S_FSTART;
                end
            end
            S_HEVAL: begin
                o_cmd.res_set = 1'b1;
                if (i_sts.cnt_full) begin
                    o_cmd.res_kind = RES_FULL;
                end else begin
                    o_cmd.res_kind = RES_HIT;
                    o_cmd.rec_upd  = 1'b1;
                    o_cmd.upd_kind = UPD_HIT;
                end
                n_state = S_DONE;
            end
            S_FSTART: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind  = SCAN_FREE;
                n_state          = S_FSCAN;
            end
            S_FSCAN: begin
                if (i_sts.scan_match) begin
                    n_state = S_ALLOC;
                end else if (i_sts.scan_end) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_NO_FREE;
                    n_state        = S_DONE;
                end
            end
            S_ALLOC: begin
                o_cmd.rec_upd  = 1'b1;
                o_cmd.upd_kind = UPD_ALLOC;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = RES_ALLOC;
                n_state        = S_DONE;
            end
            S_SREAD: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = S_SCHECK;
            end
            S_SCHECK: begin
                o_cmd.cap_slot = 1'b1;
                if (i_sts.not_held) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_NOT_HELD;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.rec_upd = 1'b1;
                o_cmd.res_set = 1'b1;
                n_state       = S_DONE;
                case (i_sts.op)
                    OP_WRITE: begin
                        o_cmd.upd_kind = UPD_DIRTY;
                        o_cmd.res_kind = RES_WRITE;
                    end
                    OP_RELEASE: begin
                        o_cmd.upd_kind = UPD_REL;
                        o_cmd.res_kind = RES_OK;
                        if (i_sts.cnt_one) begin
                            n_state = S_MSTART;
                        end
                    end
                    default: begin
                        o_cmd.upd_kind = UPD_DONE;
                        o_cmd.res_kind = RES_OK;
                    end
                endcase
            end
            S_MSTART: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_kind  = SCAN_FIND;
                n_state          = S_MSCAN;
            end
            S_MSCAN: begin
                if (i_sts.scan_match) begin
                    n_state = S_SHSTART;
                end else if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHSTART: begin
                o_cmd.shift_start = 1'b1;
                n_state           = S_SHIFT;
            end
            S_SHIFT: begin
                if (!i_sts.shift_busy) begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                o_cmd.front = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/bbc_dp.sv
// ----------------------------------------------------------------------------
// bbc_dp
// Tag and order memories, scan pipeline, order shifter and result registers.
// ----------------------------------------------------------------------------
module bbc_dp #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bbc_pkg::OP_W-1:0]   i_op,
    input  logic [bbc_pkg::DEV_W-1:0]  i_device,
    input  logic [bbc_pkg::BLK_W-1:0]  i_block_number,
    input  logic [bbc_pkg::SLOT_W-1:0] i_slot,
    input  bbc_pkg::t_cmd              i_cmd,
    output bbc_pkg::t_sts              o_sts,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [bbc_pkg::SLOT_W-1:0] o_slot_out,
    output logic                       o_hit,
    output logic                       o_needs_read,
    output logic                       o_needs_write,
    output logic [bbc_pkg::ST_W-1:0]   o_status
);
    import bbc_pkg::*;

    localparam int IW = (NUM_BUFFERS > 2) ? $clog2(NUM_BUFFERS) : 1;
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam logic [IW-1:0] LAST = IW'(NUM_BUFFERS - 1);

    logic [OP_W-1:0]   r_op;
    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [SLOT_W-1:0] r_slot;

    t_rec              rec_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_rec_tch;
    logic [IW-1:0]     ord_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_ord_tch;

    t_rec              r_rec_q;
    logic              r_rec_tch_q;
    logic [IW-1:0]     r_ord_q;
    logic              r_ord_tch_q;
    logic [IW-1:0]     r_ord_pos_q;

    logic              r_s0_vld;
    logic              r_s1_vld;
    logic              r_s2_vld;
    logic [1:0]        r_kind;
    logic [IW-1:0]     r_p;
    logic              r_s1_last;
    logic              r_s2_last;
    logic [IW-1:0]     r_s2_pos;
    logic [IW-1:0]     r_s2_e;

    logic [IW-1:0]     r_e;
    logic [IW-1:0]     r_pos;
    t_rec              r_tgt;

    logic              r_sh_act;
    logic [IW-1:0]     r_sh_p;
    logic              r_wr_vld;
    logic [IW-1:0]     r_wr_addr;

    logic [SLOT_W-1:0] r_res_slot;
    logic              r_res_hit;
    logic              r_res_rd;
    logic              r_res_wr;
    logic [ST_W-1:0]   r_res_st;
    logic              r_o_valid;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_hit;
    logic              r_o_rd;
    logic              r_o_wr;
    logic [ST_W-1:0]   r_o_st;

    logic [XW-1:0]     slot_x;
    logic [IW-1:0]     slot_idx;
    logic              slot_bad;
    logic [IW-1:0]     ord_val;
    t_rec              rec_val;
    logic [IW-1:0]     ord_raddr;
    logic [IW-1:0]     rec_raddr;
    logic              fwd;
    logic [IW-1:0]     end_pos;
    logic              match_c;
    logic              scan_match;
    logic              scan_end;
    t_rec              upd_rec;

    assign slot_x   = XW'(r_slot);
    assign slot_idx = slot_x[IW-1:0];
    assign slot_bad = (32'(r_slot) >= 32'(NUM_BUFFERS));

    assign ord_val = r_ord_tch_q ? r_ord_q : (LAST - r_ord_pos_q);
    assign rec_val = r_rec_tch_q ? r_rec_q : '0;

    assign ord_raddr = r_sh_act ? (r_sh_p - IW'(1)) : r_p;
    assign rec_raddr = i_cmd.rd_slot ? slot_idx : ord_val;

    assign fwd     = (r_kind != SCAN_FREE);
    assign end_pos = fwd ? LAST : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_slot <= i_slot;
        end
    end

    always_comb begin
        case (r_kind)
            SCAN_HIT:  match_c = (rec_val.dev == r_dev) && (rec_val.blk == r_blk);
            SCAN_FREE: match_c = (rec_val.cnt == '0) && !rec_val.dirty;
            SCAN_FIND: match_c = (r_s2_e == r_e);
            default:   match_c = 1'b0;
        endcase
    end

    assign scan_match = r_s2_vld & match_c;
    assign scan_end   = r_s2_vld & !match_c & r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_s0_vld <= 1'b1;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_kind   <= i_cmd.scan_kind;
            r_p      <= (i_cmd.scan_kind == SCAN_FREE) ? LAST : '0;
        end else if (scan_match) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld  <= r_s0_vld;
            r_s1_last <= (r_p == end_pos);
            r_s2_vld  <= r_s1_vld;
            r_s2_last <= r_s1_last;
            r_s2_pos  <= r_ord_pos_q;
            r_s2_e    <= ord_val;
            if (r_s0_vld) begin
                if (r_p == end_pos) begin
                    r_s0_vld <= 1'b0;
                end else if (fwd) begin
                    r_p <= r_p + IW'(1);
                end else begin
                    r_p <= r_p - IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_match) begin
            r_e   <= r_s2_e;
            r_pos <= r_s2_pos;
            r_tgt <= rec_val;
        end else if (i_cmd.cap_slot) begin
            r_e   <= slot_idx;
            r_tgt <= rec_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_act <= 1'b0;
            r_wr_vld <= 1'b0;
        end else if (i_cmd.shift_start) begin
            r_sh_p   <= r_pos;
            r_sh_act <= (r_pos != '0);
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld  <= r_sh_act;
            r_wr_addr <= r_sh_p;
            if (r_sh_act) begin
                r_sh_p <= r_sh_p - IW'(1);
                if (r_sh_p == IW'(1)) begin
                    r_sh_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord_q     <= ord_mem[ord_raddr];
        r_ord_pos_q <= ord_raddr;
        if (r_wr_vld) begin
            ord_mem[r_wr_addr] <= ord_val;
        end else if (i_cmd.front) begin
            ord_mem[0] <= r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord_tch   <= '0;
            r_ord_tch_q <= 1'b0;
        end else begin
            r_ord_tch_q <= r_ord_tch[ord_raddr];
            if (r_wr_vld) begin
                r_ord_tch[r_wr_addr] <= 1'b1;
            end else if (i_cmd.front) begin
                r_ord_tch[0] <= 1'b1;
            end
        end
    end

    always_comb begin
        upd_rec = r_tgt;
        case (i_cmd.upd_kind)
            UPD_HIT: begin
                upd_rec.cnt = r_tgt.cnt + CNT_ONE;
            end
            UPD_ALLOC: begin
                upd_rec.dev   = r_dev;
                upd_rec.blk   = r_blk;
                upd_rec.cnt   = CNT_ONE;
                upd_rec.valid = 1'b0;
                upd_rec.dirty = 1'b0;
            end
            UPD_DIRTY: begin
                upd_rec.dirty = 1'b1;
            end
            UPD_REL: begin
                upd_rec.cnt = r_tgt.cnt - CNT_ONE;
            end
            UPD_DONE: begin
                upd_rec.valid = 1'b1;
                upd_rec.dirty = 1'b0;
            end
            default: begin
                upd_rec = r_tgt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec_q <= rec_mem[rec_raddr];
        if (i_cmd.rec_upd) begin
            rec_mem[r_e] <= upd_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_tch   <= '0;
            r_rec_tch_q <= 1'b0;
        end else begin
            r_rec_tch_q <= r_rec_tch[rec_raddr];
            if (i_cmd.rec_upd) begin
                r_rec_tch[r_e] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_slot <= SLOT_W'(r_e);
            r_res_hit  <= 1'b0;
            r_res_rd   <= 1'b0;
            r_res_wr   <= 1'b0;
            r_res_st   <= ST_OK;
            case (i_cmd.res_kind)
                RES_HIT: begin
                    r_res_hit <= 1'b1;
                    r_res_rd  <= !r_tgt.valid;
                end
                RES_FULL: begin
                    r_res_hit <= 1'b1;
                    r_res_st  <= ST_COUNT_FULL;
                end
                RES_ALLOC: begin
                    r_res_rd <= 1'b1;
                end
                RES_NO_FREE: begin
                    r_res_slot <= '0;
                    r_res_st   <= ST_NO_FREE;
                end
                RES_NOT_HELD: begin
                    r_res_slot <= r_slot;
                    r_res_st   <= ST_NOT_HELD;
                end
                RES_WRITE: begin
                    r_res_wr <= 1'b1;
                end
                default: begin
                    r_res_st <= ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
            r_o_slot  <= r_res_slot;
            r_o_hit   <= r_res_hit;
            r_o_rd    <= r_res_rd;
            r_o_wr    <= r_res_wr;
            r_o_st    <= r_res_st;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_slot_out    = r_o_slot;
    assign o_hit         = r_o_hit;
    assign o_needs_read  = r_o_rd;
    assign o_needs_write = r_o_wr;
    assign o_status      = r_o_st;

    assign o_sts.scan_match = scan_match;
    assign o_sts.scan_end   = scan_end;
    assign o_sts.cnt_full   = (r_tgt.cnt == CNT_MAX);
    assign o_sts.cnt_one    = (r_tgt.cnt == CNT_ONE);
    assign o_sts.not_held   = slot_bad | (rec_val.cnt == '0);
    assign o_sts.shift_busy = r_sh_act | r_wr_vld;
    assign o_sts.out_free   = !r_o_valid | !i_stall;
    assign o_sts.op         = i_cmd.load ? i_op : r_op;

endmodule

FILE: dv/tb_block_buffer_cache_lru_top.sv
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru_top
// Self-checking testbench for the LRU disk buffer cache tag controller.
// ----------------------------------------------------------------------------
// Each request beat is predicted when it is accepted. The prediction uses a
// behavioral copy of the tags, reference counts, valid and dirty flags and
// the recency order. Each response beat is compared field by field with the
// oldest prediction. Directed tests cover the state after reset, every
// operation at the field extremes, reference count saturation and running
// out of free buffers. A long receiver hold-off fills the controller. Random
// traffic then runs mostly well-formed acquire, write, disk done and release
// sequences, with some noise mixed in. The sender runs in bursts and the
// receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int NBUF        = 32;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int NPOOL       = 40;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_RANDOM  = 1800;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              needs_read;
        logic              needs_write;
        logic [ST_W-1:0]   status;
    } cache_reply_t;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic [OP_W-1:0]   i_op           = OP_ACQUIRE;
    logic [DEV_W-1:0]  i_device       = '0;
    logic [BLK_W-1:0]  i_block_number = '0;
    logic [SLOT_W-1:0] i_slot         = '0;
    logic              i_stall        = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [SLOT_W-1:0] o_slot_out;
    logic              o_hit;
    logic              o_needs_read;
    logic              o_needs_write;
    logic [ST_W-1:0]   o_status;

    logic [DEV_W-1:0]  tag_dev     [NBUF];
    logic [BLK_W-1:0]  tag_blk     [NBUF];
    logic [CNT_W-1:0]  ref_cnt     [NBUF];
    logic              entry_valid [NBUF];
    logic              entry_dirty [NBUF];
    logic [SLOT_W-1:0] lru_order   [NBUF];

    logic [DEV_W-1:0]  pool_dev [NPOOL];
    logic [BLK_W-1:0]  pool_blk [NPOOL];

    cache_reply_t replies_due[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           burst_left     = 0;
    bit           gaps_on        = 1'b1;
    int unsigned  hold_calls     = 0;
    int unsigned  hold_seen      = 0;
    int           hold_left      = 0;
    rx_mode_t     rx_mode        = RX_OPEN;
    int           mode_left      = 0;
    int unsigned  rx_phase       = 0;

    block_buffer_cache_lru_top #(
        .NUM_BUFFERS(NBUF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_slot_out     (o_slot_out),
        .o_hit          (o_hit),
        .o_needs_read   (o_needs_read),
        .o_needs_write  (o_needs_write),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic cache_reply_t predict_cache_op(input logic [OP_W-1:0] op,
                                                      input logic [DEV_W-1:0] dev,
                                                      input logic [BLK_W-1:0] blk,
                                                      input logic [SLOT_W-1:0] slot);
        cache_reply_t r;
        int p;
        int e;
        r = '0;
        if (op == OP_ACQUIRE) begin
            for (p = 0; p < NBUF; p++) begin
                e = lru_order[p];
                if (tag_dev[e] == dev && tag_blk[e] == blk) begin
                    r.slot = SLOT_W'(e);
                    r.hit  = 1'b1;
                    if (ref_cnt[e] == CNT_MAX) begin
                        r.status = ST_COUNT_FULL;
                    end else begin
                        ref_cnt[e]++;
                        r.needs_read = !entry_valid[e];
                        r.status     = ST_OK;
                    end
                    return r;
                end
            end
            for (p = NBUF - 1; p >= 0; p--) begin
                e = lru_order[p];
                if (ref_cnt[e] == '0 && !entry_dirty[e]) begin
                    tag_dev[e]     = dev;
                    tag_blk[e]     = blk;
                    entry_valid[e] = 1'b0;
                    entry_dirty[e] = 1'b0;
                    ref_cnt[e]     = CNT_ONE;
                    r.slot         = SLOT_W'(e);
                    r.needs_read   = 1'b1;
                    r.status       = ST_OK;
                    return r;
                end
            end
            r.status = ST_NO_FREE;
            return r;
        end
        r.slot = slot;
        if (ref_cnt[slot] == '0) begin
            r.status = ST_NOT_HELD;
            return r;
        end
        r.status = ST_OK;
        case (op)
            OP_WRITE: begin
                entry_dirty[slot] = 1'b1;
                r.needs_write     = 1'b1;
            end
            OP_RELEASE: begin
                ref_cnt[slot]--;
                if (ref_cnt[slot] == '0) begin
                    e = 0;
                    for (p = 0; p < NBUF; p++) begin
                        if (lru_order[p] == slot) begin
                            e = p;
                        end
                    end
                    for (p = e; p > 0; p--) begin
                        lru_order[p] = lru_order[p-1];
                    end
                    lru_order[0] = slot;
                end
            end
            OP_DISK_DONE: begin
                entry_valid[slot] = 1'b1;
                entry_dirty[slot] = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_held_slot();
        int held[$];
        int e;
        for (e = 0; e < NBUF; e++) begin
            if (ref_cnt[e] != '0) begin
                held.push_back(e);
            end
        end
        if (held.size() == 0) begin
            return -1;
        end
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [DEV_W-1:0] dev,
                             input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot,
                             output cache_reply_t r);
        int gap;
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_op           = op;
        i_device       = dev;
        i_block_number = blk;
        i_slot         = slot;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        r = predict_cache_op(op, dev, blk, slot);
        replies_due.push_back(r);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 80);
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_for_replies();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_reset_state();
        cache_reply_t r;
        logic [SLOT_W-1:0] s;
        send_beat(OP_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0, r);
        s = r.slot;
        send_beat(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, s + 5'd1, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, s - 5'd3, r);
        send_beat(OP_DISK_DONE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_ACQUIRE, 8'h00, 32'h0000_0000, 5'd31, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, s, r);
        wait_for_replies();
    endtask

    task automatic test_each_op_extremes();
        cache_reply_t r;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] t;
        logic [SLOT_W-1:0] u;
        send_beat(OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31, r);
        s = r.slot;
        send_beat(OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, r);
        send_beat(OP_WRITE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_DISK_DONE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_WRITE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, s, r);
        send_beat(OP_ACQUIRE, 8'h00, 32'hFFFF_FFFF, 5'd0, r);
        t = r.slot;
        send_beat(OP_ACQUIRE, 8'hFF, 32'h0000_0000, 5'd0, r);
        u = r.slot;
        send_beat(OP_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, r);
        send_beat(OP_DISK_DONE, 8'hFF, 32'hFFFF_FFFF, s, r);
        send_beat(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, s, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, t, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, u, r);
        send_beat(OP_RELEASE, 8'h00, 32'h0000_0000, t, r);
        send_beat(OP_WRITE, 8'h00, 32'h0000_0000, 5'd31, r);
        send_beat(OP_DISK_DONE, 8'h00, 32'h0000_0000, 5'd0, r);
        wait_for_replies();
    endtask

    task automatic test_refcount_saturation();
        cache_reply_t r;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [SLOT_W-1:0] s;
        int k;
        dev = 8'hFE;
        blk = $urandom | 32'h0000_0001;
        send_beat(OP_ACQUIRE, dev, blk, 5'd0, r);
        s = r.slot;
        for (k = 0; k < 255; k++) begin
            send_beat(OP_ACQUIRE, dev, blk, SLOT_W'($urandom), r);
        end
        while (ref_cnt[s] != '0) begin
            send_beat(OP_RELEASE, 8'($urandom), $urandom, s, r);
        end
        wait_for_replies();
    endtask

    task automatic test_no_free_buffer();
        cache_reply_t r;
        int e;
        int k;
        for (k = 0; k < NBUF; k++) begin
            send_beat(OP_ACQUIRE, 8'h80 | 8'(k), $urandom, 5'd0, r);
        end
        send_beat(OP_ACQUIRE, 8'h7F, $urandom, 5'd0, r);
        for (k = 0; k < 4; k++) begin
            e = pick_held_slot();
            send_beat(OP_WRITE, 8'h00, 32'h0, SLOT_W'(e), r);
        end
        for (e = 0; e < NBUF; e++) begin
            while (ref_cnt[e] != '0) begin
                send_beat(OP_RELEASE, 8'h00, 32'h0, SLOT_W'(e), r);
            end
        end
        send_beat(OP_ACQUIRE, 8'h7E, $urandom, 5'd0, r);
        for (e = 0; e < NBUF; e++) begin
            if (entry_dirty[e]) begin
                send_beat(OP_ACQUIRE, tag_dev[e], tag_blk[e], 5'd0, r);
                if (r.status == ST_OK) begin
                    send_beat(OP_DISK_DONE, 8'h00, 32'h0, r.slot, r);
                    send_beat(OP_RELEASE, 8'h00, 32'h0, r.slot, r);
                end
            end
        end
        for (e = 0; e < NBUF; e++) begin
            while (ref_cnt[e] != '0) begin
                send_beat(OP_RELEASE, 8'h00, 32'h0, SLOT_W'(e), r);
            end
        end
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        cache_reply_t r;
        int k;
        int s;
        gaps_on = 1'b0;
        hold_calls++;
        for (k = 0; k < 24; k++) begin
            s = pick_held_slot();
            if (s < 0 || k % 3 == 0) begin
                send_beat(OP_ACQUIRE, 8'h40, 32'(k % 6), 5'd0, r);
            end else begin
                send_beat(OP_RELEASE, 8'h00, 32'h0, SLOT_W'(s), r);
            end
        end
        gaps_on = 1'b1;
        for (s = 0; s < NBUF; s++) begin
            while (ref_cnt[s] != '0) begin
                send_beat(OP_RELEASE, 8'h00, 32'h0, SLOT_W'(s), r);
            end
        end
        wait_for_replies();
    endtask

    task automatic test_random_traffic(input int n_items);
        cache_reply_t r;
        int k;
        int e;
        int s;
        int pick;
        int total;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        for (k = 0; k < NPOOL; k++) begin
            pool_dev[k] = 8'($urandom_range(0, 7));
            pool_blk[k] = $urandom;
        end
        for (k = 0; k < n_items; k++) begin
            gaps_on = ((k / 150) % 4) != 3;
            s = pick_held_slot();
            total = 0;
            for (e = 0; e < NBUF; e++) begin
                total += ref_cnt[e];
            end
            pick = $urandom_range(0, 99);
            if (s < 0 || (pick < 40 && total < 48)) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    e = $urandom_range(0, NBUF - 1);
                    dev = tag_dev[e];
                    blk = tag_blk[e];
                end else if (pick < 80) begin
                    e = $urandom_range(0, NPOOL - 1);
                    dev = pool_dev[e];
                    blk = pool_blk[e];
                end else begin
                    dev = 8'($urandom);
                    blk = $urandom;
                end
                send_beat(OP_ACQUIRE, dev, blk, SLOT_W'($urandom), r);
            end else if (pick < 55) begin
                send_beat(OP_WRITE, 8'($urandom), $urandom, SLOT_W'(s), r);
            end else if (pick < 72) begin
                send_beat(OP_DISK_DONE, 8'($urandom), $urandom, SLOT_W'(s), r);
            end else if (pick < 95) begin
                if (entry_dirty[s] && $urandom_range(0, 4) != 0) begin
                    send_beat(OP_DISK_DONE, 8'($urandom), $urandom, SLOT_W'(s), r);
                end else begin
                    send_beat(OP_RELEASE, 8'($urandom), $urandom, SLOT_W'(s), r);
                end
            end else begin
                send_beat(OP_W'($urandom_range(0, 3)), 8'($urandom), $urandom,
                          SLOT_W'($urandom_range(0, NBUF - 1)), r);
            end
        end
        gaps_on = 1'b1;
        wait_for_replies();
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else begin
            if (hold_calls != hold_seen) begin
                hold_seen = hold_calls;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall = 1'b1;
            end else begin
                case (rx_mode)
                    RX_OPEN:     i_stall = 1'b0;
                    RX_LIGHT:    i_stall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_stall = ($urandom_range(0, 9) < 7);
                    default:     i_stall = ((rx_phase % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cache_reply_t got;
        cache_reply_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.slot        = o_slot_out;
            got.hit         = o_hit;
            got.needs_read  = o_needs_read;
            got.needs_write = o_needs_write;
            got.status      = o_status;
            if (replies_due.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("%0t: response beat with none expected: slot %0d hit %0d rd %0d wr %0d st %0d",
                             $realtime, got.slot, got.hit, got.needs_read, got.needs_write,
                             got.status);
                end
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: mismatch slot %0d/%0d hit %0d/%0d rd %0d/%0d wr %0d/%0d st %0d/%0d (exp/act)",
                                 $realtime, want.slot, got.slot, want.hit, got.hit,
                                 want.needs_read, got.needs_read, want.needs_write,
                                 got.needs_write, want.status, got.status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < NBUF; k++) begin
            tag_dev[k]     = '0;
            tag_blk[k]     = '0;
            ref_cnt[k]     = '0;
            entry_valid[k] = 1'b0;
            entry_dirty[k] = 1'b0;
            lru_order[k]   = SLOT_W'(NBUF - 1 - k);
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_each_op_extremes();
        test_refcount_saturation();
        test_no_free_buffer();
        test_backpressure();
        test_random_traffic(NUM_RANDOM);
        wait_for_replies();
        repeat (2 * NBUF + 20) @(posedge i_clk);
        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/bbc_pkg.sv
rtl/bbc_ctrl.sv
rtl/bbc_dp.sv
rtl/block_buffer_cache_lru_top.sv
dv/tb_block_buffer_cache_lru_top.sv
